// ===== sv/assert_macros.svh =====
// Assertion macros used by the port checker mbrot_chk.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define CHK_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/mbrot_pkg.sv =====
// Package for the escape-time iterator: word types and fixed-point constants.
// No dependencies.
`default_nettype none
package mbrot_pkg;
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = COORD_WIDTH - 4;
  localparam int ITER_W      = 12;
  localparam int PROD_W      = 2 * COORD_WIDTH;
  localparam int ACC_W       = PROD_W + 1;
  localparam int STEP_W      = $clog2(COORD_WIDTH);
  localparam int SUM_W       = COORD_WIDTH + 6;

  localparam logic [ITER_W-1:0] MAX_ITER_RESET = ITER_W'(500);
  localparam logic [PROD_W-1:0] ESCAPE_MAG     = PROD_W'(4) << (2 * FRAC_BITS);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] c_real;
    logic signed [COORD_WIDTH-1:0] c_imag;
  } in_t;

  typedef struct packed {
    logic                          inside_res;
    logic [ITER_W-1:0]             iterations;
    logic signed [COORD_WIDTH-1:0] z_real;
    logic signed [COORD_WIDTH-1:0] z_imag;
  } out_t;
endpackage
`default_nettype wire

// ===== sv/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time iterator: z = z*z + c in Q4.28 with bit-serial multipliers.
// Depends on mbrot_pkg.
`default_nettype none
// One point at a time. Each round squares z through three radix-2 shift-add
// multipliers, then runs the escape test and, if it goes on, the update; the
// reset limit on steps is 500. A finished result waits in an output register
// while the next point is taken.
module mandelbrot_escape_time import mbrot_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output out_t             out_data_o,
  input  wire              cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire [ITER_W-1:0] cfg_data_i
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_CHECK, S_UPDATE, S_DONE} state_e;

  state_e                        state_q;
  logic [ITER_W-1:0]             max_iter_q;
  logic [ITER_W-1:0]             count_q;
  logic [STEP_W-1:0]             step_q;
  logic signed [COORD_WIDTH-1:0] x_q, y_q, cr_q, ci_q;
  logic [COORD_WIDTH-1:0]        ax_q, ay_q;
  logic                          sgn_q;
  logic [ACC_W-1:0]              pxx_q, pxy_q, pyy_q;
  logic signed [PROD_W-1:0]      diff_q, xys_q;
  logic                          inside_q;
  logic                          out_valid_q;
  out_t                          out_q;

  function automatic logic [COORD_WIDTH-1:0] mag_of(input logic signed [COORD_WIDTH-1:0] v);
    mag_of = v[COORD_WIDTH-1] ? COORD_WIDTH'(-v) : COORD_WIDTH'(v);
  endfunction

  function automatic logic [ACC_W-1:0] mul_step(input logic [ACC_W-1:0] p,
                                                input logic [COORD_WIDTH-1:0] m);
    logic [COORD_WIDTH:0] sum;
    sum = p[ACC_W-1:COORD_WIDTH] + (p[0] ? {1'b0, m} : '0);
    mul_step = {1'b0, sum, p[COORD_WIDTH-1:1]};
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi, lo;
    hi = SUM_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi)      sat = hi[COORD_WIDTH-1:0];
    else if (v < lo) sat = lo[COORD_WIDTH-1:0];
    else             sat = v[COORD_WIDTH-1:0];
  endfunction

  logic [PROD_W-1:0]        mag_w;
  logic                     go_on_w;
  logic signed [SUM_W-1:0]  re_w, im_w;
  logic signed [COORD_WIDTH-1:0] nx_w, ny_w;

  always_comb begin
    mag_w   = pxx_q[PROD_W-1:0] + pyy_q[PROD_W-1:0];
    go_on_w = (mag_w <= ESCAPE_MAG) && (count_q < max_iter_q);
    re_w    = SUM_W'(diff_q >>> FRAC_BITS) + SUM_W'(cr_q);
    im_w    = SUM_W'(xys_q >>> (FRAC_BITS - 1)) + SUM_W'(ci_q);
    nx_w    = sat(re_w);
    ny_w    = sat(im_w);
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_iter_q  <= MAX_ITER_RESET;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      step_q      <= '0;
    end else begin
      if (cfg_valid_i) max_iter_q <= cfg_data_i;
      if (out_valid_q && out_ready_i && state_q != S_DONE) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cr_q    <= in_data_i.c_real;
            ci_q    <= in_data_i.c_imag;
            x_q     <= in_data_i.c_real;
            y_q     <= in_data_i.c_imag;
            ax_q    <= mag_of(in_data_i.c_real);
            ay_q    <= mag_of(in_data_i.c_imag);
            sgn_q   <= in_data_i.c_real[COORD_WIDTH-1] ^ in_data_i.c_imag[COORD_WIDTH-1];
            pxx_q   <= ACC_W'(mag_of(in_data_i.c_real));
            pxy_q   <= ACC_W'(mag_of(in_data_i.c_real));
            pyy_q   <= ACC_W'(mag_of(in_data_i.c_imag));
            count_q <= '0;
            step_q  <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          pxx_q  <= mul_step(pxx_q, ax_q);
          pxy_q  <= mul_step(pxy_q, ay_q);
          pyy_q  <= mul_step(pyy_q, ay_q);
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(COORD_WIDTH - 1)) state_q <= S_CHECK;
        end
        S_CHECK: begin
          diff_q   <= $signed(pxx_q[PROD_W-1:0]) - $signed(pyy_q[PROD_W-1:0]);
          xys_q    <= sgn_q ? -$signed(pxy_q[PROD_W-1:0]) : $signed(pxy_q[PROD_W-1:0]);
          inside_q <= (count_q >= max_iter_q);
          state_q  <= go_on_w ? S_UPDATE : S_DONE;
        end
        S_UPDATE: begin
          x_q     <= nx_w;
          y_q     <= ny_w;
          ax_q    <= mag_of(nx_w);
          ay_q    <= mag_of(ny_w);
          sgn_q   <= nx_w[COORD_WIDTH-1] ^ ny_w[COORD_WIDTH-1];
          pxx_q   <= ACC_W'(mag_of(nx_w));
          pxy_q   <= ACC_W'(mag_of(nx_w));
          pyy_q   <= ACC_W'(mag_of(ny_w));
          count_q <= count_q + ITER_W'(1);
          step_q  <= '0;
          state_q <= S_MUL;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.inside_res <= inside_q;
            out_q.iterations <= count_q;
            out_q.z_real     <= x_q;
            out_q.z_imag     <= y_q;
            out_valid_q      <= 1'b1;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/mbrot_chk.sv =====
// Port checker for mandelbrot_escape_time, bound to that module by a bind.
// Depends on mbrot_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module mbrot_chk import mbrot_pkg::*; (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              in_valid_i,
  input wire              in_ready_o,
  input wire              out_valid_o,
  input wire              out_ready_i,
  input out_t             out_data_o,
  input wire              cfg_ready_o
);
  `CHK_PROP(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result word dropped")
  `CHK_PROP(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_data_o), "result word changed")
  `CHK_PROP(a_busy_after_in, in_valid_i && in_ready_o |=> !in_ready_o, "second word taken while busy")
  `CHK_NEVER(a_cfg_ready, !cfg_ready_o, "config port stalled")
endmodule

bind mandelbrot_escape_time mbrot_chk u_mbrot_chk (.*);
`default_nettype wire
